>>> design/letterbox_pointer_mapper_defines.svh
// Assertion macros for the letterbox pointer mapper checker.
// Depends on nothing; included by the checker module only.
`ifndef LETTERBOX_POINTER_MAPPER_DEFINES_SVH
`define LETTERBOX_POINTER_MAPPER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define LPM_ASSERT_IMPLY(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("letterbox pointer mapper: implication failed");

// Next-cycle implication, held off while reset is asserted.
`define LPM_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("letterbox pointer mapper: next-cycle check failed");

`endif

>>> design/lpm_pkg.sv
// Shared constants for the letterbox pointer mapper: field widths,
// register indexes and the bit layout of the result request.
package lpm_pkg;

  localparam int FracBits  = 8;
  localparam int SizeBits  = 13;
  localparam int PosBits   = 14;
  localparam int PtrBits   = 23;
  localparam int CposBits  = 23;
  localparam int CsizeBits = 21;
  localparam int MapBits   = 13;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 14;

  localparam int InDataBits  = 48;
  localparam int OutDataBits = 120;

  // Result request layout, lowest bit first.
  localparam int OutCxLsb     = 0;
  localparam int OutCyLsb     = OutCxLsb + CposBits;
  localparam int OutCwLsb     = OutCyLsb + CposBits;
  localparam int OutChLsb     = OutCwLsb + CsizeBits;
  localparam int OutMxLsb     = OutChLsb + CsizeBits;
  localparam int OutMyLsb     = OutMxLsb + MapBits;
  localparam int OutInsideBit = OutMyLsb + MapBits;
  localparam int OutOkBit     = OutInsideBit + 1;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_CWIDTH = 3'd2,
    REG_CHEIGHT = 3'd3,
    REG_GWIDTH = 3'd4,
    REG_GHEIGHT = 3'd5
  } cfg_reg_t;

endpackage

>>> design/lpm_div_cell.sv
// One restoring-division cell: while en is high, it settles one quotient bit
// per cycle and hands remainder, divisor, partial quotient and sideband to the next cell.
// Depends on nothing outside this file.
module lpm_div_cell #(
  parameter int NumW  = 34,
  parameter int DenW  = 13,
  parameter int QuoW  = 21,
  parameter int SideW = 1,
  parameter int Shift = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NumW-1:0]  in_rem,
  input  logic [DenW-1:0]  in_den,
  input  logic [QuoW-1:0]  in_quo,
  input  logic [SideW-1:0] in_side,
  output logic             out_valid,
  output logic [NumW-1:0]  out_rem,
  output logic [DenW-1:0]  out_den,
  output logic [QuoW-1:0]  out_quo,
  output logic [SideW-1:0] out_side
);

  localparam int WideW = NumW + DenW;

  logic [WideW-1:0] den_sh;
  logic             take;
  logic [NumW-1:0]  rem_nxt;

  assign den_sh  = WideW'(in_den) << Shift;
  assign take    = WideW'(in_rem) >= den_sh;
  assign rem_nxt = take ? (in_rem - den_sh[NumW-1:0]) : in_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_nxt;
      out_den  <= in_den;
      out_quo  <= {in_quo[QuoW-2:0], take};
      out_side <= in_side;
    end
  end

endmodule

>>> design/letterbox_pointer_mapper.sv
// Letterbox pointer mapper, top level: fits the game aspect into the
// container and maps pointer positions to game pixels.
// Depends on lpm_pkg and lpm_div_cell.
//
// Use: configuration registers (container left, top, width, height, game
// width, height) are written on the cfg_ channel, which is always ready.
// Each request on the in_ channel carries one pointer position (x, y, signed
// with eight fraction bits) and yields exactly one result request on the
// out_ channel: the fitted content rectangle, the game pixel, an inside flag
// and an ok flag. Configuration is to be rewritten only while no request is
// in flight; the user must keep to this, as the block does not enforce it.
// Throughput is one request per cycle unless the receiver stalls. The
// division cells form one chain of 21 cells for the content size and one of
// 14 for each mapped axis, each cell settling one quotient bit per cycle.
// The whole pipeline moves under one enable. When the receiver stalls with a
// result held in the output register, every stage holds and in_tready drops;
// once the result is taken the pipeline moves again with no lost cycle.
// Reset clears all valid flags and loads the register defaults (a 640 by 480
// container at the origin and a 640 by 480 game).
module letterbox_pointer_mapper (
  input  logic clk,
  input  logic rst_n,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpm_pkg::CfgIdxBits-1:0]      cfg_index,
  input  logic [lpm_pkg::CfgDataBits-1:0]     cfg_data,
  // Pointer requests.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pointer_x [22:0], pointer_y [45:23], zero padding [47:46]
  input  logic [lpm_pkg::InDataBits-1:0]      in_tdata,
  // Result requests.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // content_x [22:0], content_y [45:23], content_w [66:46],
  // content_h [87:67], mapped_x [100:88], mapped_y [113:101],
  // inside_res [114], map_ok [115], zero padding [119:116]
  output logic [lpm_pkg::OutDataBits-1:0]     out_tdata
);

  localparam int F    = lpm_pkg::FracBits;
  localparam int SB   = lpm_pkg::SizeBits;
  localparam int PB   = lpm_pkg::PosBits;
  localparam int PtrW = lpm_pkg::PtrBits;
  localparam int CpW  = lpm_pkg::CposBits;
  localparam int CsW  = lpm_pkg::CsizeBits;
  localparam int MW   = lpm_pkg::MapBits;
  localparam int ProdW = 2 * SB;
  localparam int Num1W = ProdW + F;
  localparam int Q1W   = CsW;
  localparam int Side1W = 2 * PtrW + 2;
  localparam int LocW  = CpW + 2;
  localparam int AbsW  = PtrW - 1;
  localparam int Num2W = AbsW + SB;
  localparam int Q2W   = MW + 1;
  localparam int Side2W = 2 * CpW + 3;

  // Configuration registers.
  logic [PB-1:0] left_r, top_r;
  logic [SB-1:0] cw_r, ch_r, gw_r, gh_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      top_r  <= '0;
      cw_r   <= SB'(640);
      ch_r   <= SB'(480);
      gw_r   <= SB'(640);
      gh_r   <= SB'(480);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lpm_pkg::REG_LEFT:    left_r <= cfg_data[PB-1:0];
        lpm_pkg::REG_TOP:     top_r  <= cfg_data[PB-1:0];
        lpm_pkg::REG_CWIDTH:  cw_r   <= cfg_data[SB-1:0];
        lpm_pkg::REG_CHEIGHT: ch_r   <= cfg_data[SB-1:0];
        lpm_pkg::REG_GWIDTH:  gw_r   <= cfg_data[SB-1:0];
        lpm_pkg::REG_GHEIGHT: gh_r   <= cfg_data[SB-1:0];
        default: ;
      endcase
    end
  end

  // Global pipeline enable: move unless a result waits on a stalled receiver.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage A: aspect cross-products and the pointer.
  logic             a_valid_r;
  logic [ProdW-1:0] a_p1_r, a_p2_r;
  logic [PtrW-1:0]  a_px_r, a_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p1_r <= ProdW'(cw_r) * ProdW'(gh_r);
      a_p2_r <= ProdW'(ch_r) * ProdW'(gw_r);
      a_px_r <= in_tdata[PtrW-1:0];
      a_py_r <= in_tdata[2*PtrW-1:PtrW];
    end
  end

  // Pillarbox when the container is relatively wider than the game.
  logic a_pill, a_zero;
  assign a_pill = a_p1_r > a_p2_r;
  assign a_zero = (cw_r == '0) || (ch_r == '0) || (gw_r == '0) || (gh_r == '0);

  // Content-size division chain.
  logic              d1_valid [0:Q1W];
  logic [Num1W-1:0]  d1_rem   [0:Q1W];
  logic [SB-1:0]     d1_den   [0:Q1W];
  logic [Q1W-1:0]    d1_quo   [0:Q1W];
  logic [Side1W-1:0] d1_side  [0:Q1W];

  assign d1_valid[0] = a_valid_r;
  assign d1_rem[0]   = {(a_pill ? a_p2_r : a_p1_r), F'(0)};
  assign d1_den[0]   = a_pill ? gh_r : gw_r;
  assign d1_quo[0]   = '0;
  assign d1_side[0]  = {a_zero, a_pill, a_py_r, a_px_r};

  for (genvar k = 0; k < Q1W; k++) begin : g_fit
    lpm_div_cell #(
      .NumW(Num1W), .DenW(SB), .QuoW(Q1W), .SideW(Side1W), .Shift(Q1W - 1 - k)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(d1_valid[k]), .in_rem(d1_rem[k]), .in_den(d1_den[k]),
      .in_quo(d1_quo[k]), .in_side(d1_side[k]),
      .out_valid(d1_valid[k+1]), .out_rem(d1_rem[k+1]), .out_den(d1_den[k+1]),
      .out_quo(d1_quo[k+1]), .out_side(d1_side[k+1])
    );
  end

  // Stage C: content rectangle.
  logic [PtrW-1:0] c_px, c_py;
  logic            c_pill, c_zero;
  logic [Q1W-1:0]  fit;
  logic [CsW-1:0]  cw_fix, ch_fix;
  logic [CpW-1:0]  left_fix, top_fix;
  logic [CpW-1:0]  cx_nxt, cy_nxt;
  logic [CsW-1:0]  wid_nxt, hgt_nxt;

  assign {c_zero, c_pill, c_py, c_px} = d1_side[Q1W];
  assign fit      = d1_quo[Q1W];
  assign cw_fix   = {cw_r, F'(0)};
  assign ch_fix   = {ch_r, F'(0)};
  assign left_fix = CpW'({left_r, F'(0)});
  assign top_fix  = CpW'({top_r, F'(0)});

  always_comb begin
    cx_nxt  = left_fix;
    cy_nxt  = top_fix;
    wid_nxt = '0;
    hgt_nxt = '0;
    if (!c_zero) begin
      if (c_pill) begin
        wid_nxt = fit;
        hgt_nxt = ch_fix;
        cx_nxt  = left_fix + CpW'((cw_fix - fit) >> 1);
      end else begin
        wid_nxt = cw_fix;
        hgt_nxt = fit;
        cy_nxt  = top_fix + CpW'((ch_fix - fit) >> 1);
      end
    end
  end

  logic            c_valid_r, c_ok_r;
  logic [CpW-1:0]  c_cx_r, c_cy_r;
  logic [CsW-1:0]  c_wid_r, c_hgt_r;
  logic [PtrW-1:0] c_px_r, c_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= d1_valid[Q1W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ok_r  <= !c_zero && (fit != '0);
      c_cx_r  <= cx_nxt;
      c_cy_r  <= cy_nxt;
      c_wid_r <= wid_nxt;
      c_hgt_r <= hgt_nxt;
      c_px_r  <= c_px;
      c_py_r  <= c_py;
    end
  end

  // Stage D: local offsets and the inside test.
  logic signed [LocW-1:0] lx_nxt, ly_nxt;
  logic                   inside_nxt;

  assign lx_nxt = LocW'($signed(c_px_r)) - $signed({2'b00, c_cx_r});
  assign ly_nxt = LocW'($signed(c_py_r)) - $signed({2'b00, c_cy_r});
  assign inside_nxt = c_ok_r && !lx_nxt[LocW-1] && !ly_nxt[LocW-1]
                   && (lx_nxt[LocW-2:0] < (LocW-1)'(c_wid_r))
                   && (ly_nxt[LocW-2:0] < (LocW-1)'(c_hgt_r));

  logic                   d_valid_r, d_ok_r, d_inside_r;
  logic signed [LocW-1:0] d_lx_r, d_ly_r;
  logic [CpW-1:0]         d_cx_r, d_cy_r;
  logic [CsW-1:0]         d_wid_r, d_hgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ok_r     <= c_ok_r;
      d_inside_r <= inside_nxt;
      d_lx_r     <= lx_nxt;
      d_ly_r     <= ly_nxt;
      d_cx_r     <= c_cx_r;
      d_cy_r     <= c_cy_r;
      d_wid_r    <= c_wid_r;
      d_hgt_r    <= c_hgt_r;
    end
  end

  // Stage E: offset times game size; non-positive offsets map to zero.
  logic [AbsW-1:0] ax, ay;
  assign ax = (!d_lx_r[LocW-1] && (d_lx_r != '0)) ? d_lx_r[AbsW-1:0] : '0;
  assign ay = (!d_ly_r[LocW-1] && (d_ly_r != '0)) ? d_ly_r[AbsW-1:0] : '0;

  // An offset at or past the content size is flagged and, on an ok mapping,
  // clamps to the last pixel, whatever quotient the chains compute for it.
  logic ovx_nxt, ovy_nxt;
  assign ovx_nxt = !d_lx_r[LocW-1] && (d_lx_r[LocW-2:0] >= (LocW-1)'(d_wid_r));
  assign ovy_nxt = !d_ly_r[LocW-1] && (d_ly_r[LocW-2:0] >= (LocW-1)'(d_hgt_r));

  logic             e_valid_r, e_ok_r, e_inside_r, e_ovx_r, e_ovy_r;
  logic [Num2W-1:0] e_nx_r, e_ny_r;
  logic [CpW-1:0]   e_cx_r, e_cy_r;
  logic [CsW-1:0]   e_wid_r, e_hgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_ok_r     <= d_ok_r;
      e_inside_r <= d_inside_r;
      e_ovx_r    <= ovx_nxt;
      e_ovy_r    <= ovy_nxt;
      e_nx_r     <= Num2W'(ax) * Num2W'(gw_r);
      e_ny_r     <= Num2W'(ay) * Num2W'(gh_r);
      e_cx_r     <= d_cx_r;
      e_cy_r     <= d_cy_r;
      e_wid_r    <= d_wid_r;
      e_hgt_r    <= d_hgt_r;
    end
  end

  // Mapping chains; the overflow flags ride along in the x sideband.
  logic              mx_valid [0:Q2W];
  logic [Num2W-1:0]  mx_rem   [0:Q2W];
  logic [CsW-1:0]    mx_den   [0:Q2W];
  logic [Q2W-1:0]    mx_quo   [0:Q2W];
  logic [Side2W-1:0] mx_side  [0:Q2W];
  logic [Num2W-1:0]  my_rem   [0:Q2W];
  logic [CsW-1:0]    my_den   [0:Q2W];
  logic [Q2W-1:0]    my_quo   [0:Q2W];
  logic              my_side  [0:Q2W];

  assign mx_valid[0] = e_valid_r;
  assign mx_rem[0]   = e_nx_r;
  assign mx_den[0]   = e_wid_r;
  assign mx_quo[0]   = '0;
  assign mx_side[0]  = {e_ovy_r, e_ovx_r, e_ok_r, e_cy_r, e_cx_r};
  assign my_rem[0]   = e_ny_r;
  assign my_den[0]   = e_hgt_r;
  assign my_quo[0]   = '0;
  assign my_side[0]  = e_inside_r;

  for (genvar k = 0; k < Q2W; k++) begin : g_map
    lpm_div_cell #(
      .NumW(Num2W), .DenW(CsW), .QuoW(Q2W), .SideW(Side2W), .Shift(Q2W - 1 - k)
    ) u_cell_x (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(mx_valid[k]), .in_rem(mx_rem[k]), .in_den(mx_den[k]),
      .in_quo(mx_quo[k]), .in_side(mx_side[k]),
      .out_valid(mx_valid[k+1]), .out_rem(mx_rem[k+1]), .out_den(mx_den[k+1]),
      .out_quo(mx_quo[k+1]), .out_side(mx_side[k+1])
    );
    lpm_div_cell #(
      .NumW(Num2W), .DenW(CsW), .QuoW(Q2W), .SideW(1), .Shift(Q2W - 1 - k)
    ) u_cell_y (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(mx_valid[k]), .in_rem(my_rem[k]), .in_den(my_den[k]),
      .in_quo(my_quo[k]), .in_side(my_side[k]),
      .out_valid(), .out_rem(my_rem[k+1]), .out_den(my_den[k+1]),
      .out_quo(my_quo[k+1]), .out_side(my_side[k+1])
    );
  end

  // Output register: clamp to the game bounds and pack the result.
  logic           f_ok, f_ovx, f_ovy;
  logic [CpW-1:0] f_cx, f_cy;
  logic [MW-1:0]  mx_nxt, my_nxt;

  assign {f_ovy, f_ovx, f_ok, f_cy, f_cx} = mx_side[Q2W];

  always_comb begin
    mx_nxt = '0;
    my_nxt = '0;
    if (f_ok) begin
      mx_nxt = (f_ovx || (mx_quo[Q2W] >= Q2W'(gw_r))) ? (gw_r - 1'b1)
                                                      : mx_quo[Q2W][MW-1:0];
      my_nxt = (f_ovy || (my_quo[Q2W] >= Q2W'(gh_r))) ? (gh_r - 1'b1)
                                                      : my_quo[Q2W][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= mx_valid[Q2W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= {4'b0000, f_ok, my_side[Q2W] && f_ok, my_nxt, mx_nxt,
                    my_den[Q2W], mx_den[Q2W], f_cy, f_cx};
    end
  end

endmodule

>>> design/lpm_checker.sv
// Port-level checker for the letterbox pointer mapper, bound to the top level.
// Depends on lpm_pkg and letterbox_pointer_mapper_defines.svh.
`include "letterbox_pointer_mapper_defines.svh"

module lpm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lpm_pkg::OutDataBits-1:0] out_tdata
);

  logic ok, in_rect;
  logic [lpm_pkg::MapBits-1:0] mx, my;

  assign ok      = out_tdata[lpm_pkg::OutOkBit];
  assign in_rect = out_tdata[lpm_pkg::OutInsideBit];
  assign mx      = out_tdata[lpm_pkg::OutMxLsb +: lpm_pkg::MapBits];
  assign my      = out_tdata[lpm_pkg::OutMyLsb +: lpm_pkg::MapBits];

  // A stalled result stays offered and unchanged.
  `LPM_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `LPM_ASSERT_NEXT(a_hold_data, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  // The pointer can only be inside a valid content rectangle.
  `LPM_ASSERT_IMPLY(a_inside_ok, clk, rst_n, out_tvalid && in_rect, ok)
  // An invalid mapping reports the origin pixel.
  `LPM_ASSERT_IMPLY(a_bad_zero, clk, rst_n, out_tvalid && !ok, (mx == '0) && (my == '0))

endmodule

bind letterbox_pointer_mapper lpm_checker u_lpm_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
